>>> hdl/fcr_pkg.sv
package fcr_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int TAG_BYTES_DEF    = 16;
  localparam int TAG_BYTES_MAX    = 64;
  localparam int TLEN_W           = $clog2(TAG_BYTES_MAX + 1);
  localparam int QDEPTH           = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 8;

  localparam logic [7:0] START_BYTE_RST  = 8'd60;
  localparam logic [7:0] END_BYTE_RST    = 8'd62;
  localparam logic [7:0] MOTION_CODE_RST = 8'd77;
  localparam logic [7:0] TAG_CODE_RST    = 8'd82;
  localparam logic [7:0] ALARM_CODE_RST  = 8'd69;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 3'd0,
    CFG_END    = 3'd1,
    CFG_MOTION = 3'd2,
    CFG_TAG    = 3'd3,
    CFG_ALARM  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_MOTION     = 3'd1,
    EV_TAG        = 3'd2,
    EV_ALARM      = 3'd3,
    EV_UNKNOWN    = 3'd4,
    EV_EMPTY      = 3'd5,
    EV_TAG_NODATA = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MOTION,
    OP_TAG,
    OP_ALARM,
    OP_UNKNOWN,
    OP_EMPTY,
    OP_TAG_NODATA,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] motion_code;
    logic [7:0] tag_code;
    logic [7:0] alarm_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [3:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       motion_flag;
    logic       tag_flag;
    logic       alarm_flag;
    logic [4:0] tag_length;
    logic [7:0] read_byte;
    logic       in_message;
  } rsp_t;

  // Classified command handed from the framer to the executor.
  typedef struct packed {
    op_e               op;
    logic [TLEN_W-1:0] tag_len;
    logic              bank;
    logic [3:0]        read_index;
    logic              in_message;
  } cmd_t;

  function automatic event_e event_of(op_e op);
    event_e ev;
    case (op)
      OP_MOTION:     ev = EV_MOTION;
      OP_TAG:        ev = EV_TAG;
      OP_ALARM:      ev = EV_ALARM;
      OP_UNKNOWN:    ev = EV_UNKNOWN;
      OP_EMPTY:      ev = EV_EMPTY;
      OP_TAG_NODATA: ev = EV_TAG_NODATA;
      default:       ev = EV_NONE;
    endcase
    return ev;
  endfunction

endpackage

>>> hdl/fcr_if.sv
interface fcr_req_if;
  import fcr_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fcr_rsp_if;
  import fcr_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/fcr_tag_ram.sv
module fcr_tag_ram #(
  parameter int AW = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [2**AW];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/fcr_front.sv
module fcr_front #(
  parameter int BUFFER_BYTES = fcr_pkg::BUFFER_BYTES_DEF,
  parameter int TAG_BYTES    = fcr_pkg::TAG_BYTES_DEF,
  parameter int AW           = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcr_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fcr_pkg::req_t  in_data_i,
  input  logic           q_full_i,
  output logic           push_o,
  output fcr_pkg::cmd_t  push_data_o,
  input  logic           tag_retire_i,
  output logic           wr_en_o,
  output logic [AW-1:0]  wr_addr_o,
  output logic [7:0]     wr_data_o
);
  import fcr_pkg::*;

  localparam int BCNT_W = $clog2(BUFFER_BYTES);
  localparam int TIDX_W = AW - 1;

  logic              inside_q, inside_d;
  logic [BCNT_W-1:0] cnt_q, cnt_d;
  logic [BCNT_W-1:0] cnt_m1;
  logic [7:0]        cmd_byte_q, cmd_byte_d;
  logic              wbank_q, wbank_d;
  logic              tag_busy_q, tag_busy_d;
  logic              accept;
  logic              stage_wr;
  cmd_t              cmd;

  // While a tag latch is on its way to the executor, the staging bank is
  // about to swap roles with the tag bank, so no new item is taken.
  assign in_ready_o = !q_full_i && !tag_busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_m1     = cnt_q - BCNT_W'(1);

  always_comb begin
    inside_d       = inside_q;
    cnt_d          = cnt_q;
    cmd_byte_d     = cmd_byte_q;
    wbank_d        = wbank_q;
    stage_wr       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.tag_len    = '0;
    cmd.bank       = wbank_q;
    cmd.read_index = in_data_i.read_index;
    case (in_data_i.req_type)
      REQ_BYTE: begin
        if (in_data_i.rx_byte == cfg_i.start_byte) begin
          inside_d = 1'b1;
          cnt_d    = '0;
        end else if (inside_q) begin
          if (in_data_i.rx_byte == cfg_i.end_byte) begin
            inside_d = 1'b0;
            cnt_d    = '0;
            if (cnt_q == '0) begin
              cmd.op = OP_EMPTY;
            end else if (cmd_byte_q == cfg_i.motion_code) begin
              cmd.op = OP_MOTION;
            end else if (cmd_byte_q == cfg_i.tag_code) begin
              if (32'(cnt_q) < 32'd2) begin
                cmd.op = OP_TAG_NODATA;
              end else begin
                cmd.op  = OP_TAG;
                wbank_d = ~wbank_q;
                if (32'(cnt_m1) > 32'(TAG_BYTES)) begin
                  cmd.tag_len = TLEN_W'(TAG_BYTES);
                end else begin
                  cmd.tag_len = TLEN_W'(cnt_m1);
                end
              end
            end else if (cmd_byte_q == cfg_i.alarm_code) begin
              cmd.op = OP_ALARM;
            end else begin
              cmd.op = OP_UNKNOWN;
            end
          end else if (32'(cnt_q) < 32'(BUFFER_BYTES - 1)) begin
            if (cnt_q == '0) begin
              cmd_byte_d = in_data_i.rx_byte;
            end else if (32'(cnt_q) <= 32'(TAG_BYTES)) begin
              stage_wr = 1'b1;
            end
            cnt_d = cnt_q + BCNT_W'(1);
          end
        end
      end
      REQ_CLEAR: cmd.op = OP_CLEAR;
      REQ_READ:  cmd.op = OP_READ;
      default:   cmd.op = OP_NONE;
    endcase
    cmd.in_message = inside_d;

    tag_busy_d = tag_busy_q;
    if (accept && (cmd.op == OP_TAG)) begin
      tag_busy_d = 1'b1;
    end else if (tag_retire_i) begin
      tag_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      cnt_q      <= '0;
      cmd_byte_q <= '0;
      wbank_q    <= 1'b1;
      tag_busy_q <= 1'b0;
    end else begin
      tag_busy_q <= tag_busy_d;
      if (accept) begin
        inside_q   <= inside_d;
        cnt_q      <= cnt_d;
        cmd_byte_q <= cmd_byte_d;
        wbank_q    <= wbank_d;
      end
    end
  end

  assign push_o      = accept;
  assign push_data_o = cmd;
  assign wr_en_o     = accept && stage_wr;
  assign wr_addr_o   = {wbank_q, TIDX_W'(cnt_m1)};
  assign wr_data_o   = in_data_i.rx_byte;

  a_tag_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push_o && (push_data_o.op == OP_TAG)) |=> !in_ready_o
  ) else $error("input taken while a tag latch is pending");

endmodule

>>> hdl/fcr_queue.sv
module fcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fcr_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fcr_pkg::cmd_t data_o
);
  import fcr_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (32'(wptr_q) == QDEPTH - 1) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (32'(rptr_q) == QDEPTH - 1) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign full_o  = (count_q == CNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  a_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o
  ) else $error("command queue overflow");

endmodule

>>> hdl/fcr_back.sv
module fcr_back #(
  parameter int TAG_BYTES = fcr_pkg::TAG_BYTES_DEF,
  parameter int AW        = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  fcr_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          tag_retire_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fcr_pkg::rsp_t out_data_o
);
  import fcr_pkg::*;

  localparam int TCNT_W = $clog2(TAG_BYTES + 1);
  localparam int TIDX_W = AW - 1;

  logic              out_valid_q;
  logic              load;
  logic              motion_q, motion_d;
  logic              tagf_q, tagf_d;
  logic              alarm_q, alarm_d;
  logic [TCNT_W-1:0] tag_count_q, tag_count_d;
  logic              active_q, active_d;
  logic [2:0]        ev_q;
  logic              in_msg_q;
  logic              rd_hit_q, rd_hit_d;

  // The output register doubles as the read register of the tag memory.
  assign load = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    motion_d    = motion_q;
    tagf_d      = tagf_q;
    alarm_d     = alarm_q;
    tag_count_d = tag_count_q;
    active_d    = active_q;
    rd_hit_d    = 1'b0;
    case (q_data_i.op)
      OP_MOTION: motion_d = 1'b1;
      OP_ALARM:  alarm_d  = 1'b1;
      OP_TAG: begin
        tagf_d      = 1'b1;
        tag_count_d = TCNT_W'(q_data_i.tag_len);
        active_d    = q_data_i.bank;
      end
      OP_CLEAR: begin
        motion_d    = 1'b0;
        tagf_d      = 1'b0;
        alarm_d     = 1'b0;
        tag_count_d = '0;
      end
      OP_READ: rd_hit_d = (32'(q_data_i.read_index) < 32'(tag_count_q));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      motion_q    <= 1'b0;
      tagf_q      <= 1'b0;
      alarm_q     <= 1'b0;
      tag_count_q <= '0;
      active_q    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        motion_q    <= motion_d;
        tagf_q      <= tagf_d;
        alarm_q     <= alarm_d;
        tag_count_q <= tag_count_d;
        active_q    <= active_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q     <= event_of(q_data_i.op);
      in_msg_q <= q_data_i.in_message;
      rd_hit_q <= rd_hit_d;
    end
  end

  assign q_pop_o      = load;
  assign tag_retire_o = load && (q_data_i.op == OP_TAG);
  assign rd_en_o      = load && (q_data_i.op == OP_READ);
  assign rd_addr_o    = {active_q, TIDX_W'(q_data_i.read_index)};

  assign out_valid_o            = out_valid_q;
  assign out_data_o.event_code  = ev_q;
  assign out_data_o.motion_flag = motion_q;
  assign out_data_o.tag_flag    = tagf_q;
  assign out_data_o.alarm_flag  = alarm_q;
  assign out_data_o.tag_length  = 5'(tag_count_q);
  assign out_data_o.read_byte   = rd_hit_q ? rd_data_i : 8'd0;
  assign out_data_o.in_message  = in_msg_q;

  a_clear_drops_all: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (load && (q_data_i.op == OP_CLEAR)) |=>
      (!motion_q && !tagf_q && !alarm_q && (tag_count_q == '0))
  ) else $error("clear left flags or tag behind");

  a_tag_has_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (load && (q_data_i.op == OP_TAG)) |=> (tagf_q && (tag_count_q != '0))
  ) else $error("tag latched without data");

endmodule

>>> hdl/framed_command_receiver_unit.sv
// Framed command receiver.
// req_i carries one request per transaction: a received byte, a clear of the
// flags and tag, or a read of one latched tag byte. rsp_o returns exactly one
// result per request, in order, with the event of that request and the flags,
// tag length and framing state after it. The cfg_we_i port sets the framing
// and command bytes; write it only while no request is outstanding.
// A request accepted at one clock edge enters the command queue at that edge
// and moves to the output register once it heads the queue and the output
// register is empty or being read. One request is accepted per cycle while
// the command queue has room, except that a message closing with a tag
// command blocks req_i until the executor takes that command and swaps the
// staging and tag banks of the tag memory, a wait that lasts longer while
// rsp_o stalls. The framer feeds a two-entry command queue in front of the
// output register; when rsp_o stalls, up to three results are held before
// req_i ready drops. Reset clears the framing state, flags and tag length and
// loads the default framing and command bytes; no clearing pass is needed.
module framed_command_receiver_unit #(
  parameter int BUFFER_BYTES = fcr_pkg::BUFFER_BYTES_DEF,
  parameter int TAG_BYTES    = fcr_pkg::TAG_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fcr_req_if.sink                        req_i,
  fcr_rsp_if.source                      rsp_o
);
  import fcr_pkg::*;

  localparam int TIDX_W = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam int AW     = TIDX_W + 1;

  cfg_t          cfg_q;
  logic          push, q_full, q_valid, q_pop, tag_retire;
  cmd_t          push_data, q_data;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= START_BYTE_RST;
      cfg_q.end_byte    <= END_BYTE_RST;
      cfg_q.motion_code <= MOTION_CODE_RST;
      cfg_q.tag_code    <= TAG_CODE_RST;
      cfg_q.alarm_code  <= ALARM_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START:  cfg_q.start_byte  <= cfg_wdata_i;
        CFG_END:    cfg_q.end_byte    <= cfg_wdata_i;
        CFG_MOTION: cfg_q.motion_code <= cfg_wdata_i;
        CFG_TAG:    cfg_q.tag_code    <= cfg_wdata_i;
        CFG_ALARM:  cfg_q.alarm_code  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fcr_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .TAG_BYTES    (TAG_BYTES),
    .AW           (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .in_data_i    (req_i.data),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data),
    .tag_retire_i (tag_retire),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  fcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  fcr_tag_ram #(
    .AW (AW)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  fcr_back #(
    .TAG_BYTES (TAG_BYTES),
    .AW        (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .tag_retire_o (tag_retire),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_data_o   (rsp_o.data)
  );

endmodule
